[rtl/anp_pkg.sv]
// ----------------------------------------------------------------------------
// anp_pkg
// Types, constants and character helpers shared by the ASCII number parser
// and its channel interfaces.
// ----------------------------------------------------------------------------
package anp_pkg;

  // Field widths fixed by the item formats.
  localparam int CharW  = 8;
  localparam int ValueW = 64;
  localparam int EndW   = 13;
  localparam int BaseW  = 5;

  // Default string length limit for the position counter.
  localparam int MaxCharsDefault = 4096;

  typedef logic [CharW-1:0]  char_t;
  typedef logic [ValueW-1:0] value_t;
  typedef logic [EndW-1:0]   end_t;
  typedef logic [BaseW-1:0]  base_t;

  // Radix codes.
  localparam base_t BaseAuto = 5'd0;
  localparam base_t BaseOct  = 5'd8;
  localparam base_t BaseDec  = 5'd10;
  localparam base_t BaseHex  = 5'd16;

  // Digit value that marks a character that is no hex digit at all.
  localparam base_t DigitNone = 5'd16;

  // Characters of interest.
  localparam char_t CharNul    = 8'h00;
  localparam char_t CharTab    = 8'h09;
  localparam char_t CharCr     = 8'h0D;
  localparam char_t CharSpace  = 8'h20;
  localparam char_t CharPlus   = 8'h2B;
  localparam char_t CharMinus  = 8'h2D;
  localparam char_t CharZero   = 8'h30;
  localparam char_t CharNine   = 8'h39;
  localparam char_t CharUpperA = 8'h41;
  localparam char_t CharUpperF = 8'h46;
  localparam char_t CharLowerA = 8'h61;
  localparam char_t CharLowerF = 8'h66;
  localparam char_t CharUpperX = 8'h58;
  localparam char_t CharLowerX = 8'h78;
  localparam char_t LetterBias = 8'd10;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_NUMBER_BASE  = 1'b0,
    REG_SIGNED_PARSE = 1'b1
  } reg_index_t;

  // Parse phases of one string.
  typedef enum logic [6:0] {
    PH_WS1     = 7'b0000001,
    PH_WS2     = 7'b0000010,
    PH_ZERO    = 7'b0000100,
    PH_X       = 7'b0001000,
    PH_HEXZERO = 7'b0010000,
    PH_DIGITS  = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  // Space, tab, newline, vertical tab, form feed and carriage return.
  function automatic logic is_ws(input char_t c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  // Hex digit value of a character, DigitNone for anything else.
  function automatic base_t digit_of(input char_t c);
    char_t d;
    d = CharNul;
    if ((c >= CharZero) && (c <= CharNine)) begin
      d = c - CharZero;
    end else if ((c >= CharLowerA) && (c <= CharLowerF)) begin
      d = c - CharLowerA + LetterBias;
    end else if ((c >= CharUpperA) && (c <= CharUpperF)) begin
      d = c - CharUpperA + LetterBias;
    end else begin
      d = char_t'(DigitNone);
    end
    return d[BaseW-1:0];
  endfunction

endpackage

[rtl/anp_in_if.sv]
// ----------------------------------------------------------------------------
// anp_in_if
// Character channel: one character of the string per item, last one marked.
// ----------------------------------------------------------------------------
interface anp_in_if;
  logic           valid;
  logic           ready;
  anp_pkg::char_t char_code;
  logic           is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

[rtl/anp_out_if.sv]
// ----------------------------------------------------------------------------
// anp_out_if
// Result channel: parsed value and end offset, one item per string.
// ----------------------------------------------------------------------------
interface anp_out_if;
  logic            valid;
  logic            ready;
  anp_pkg::value_t value;
  logic            end_valid;
  anp_pkg::end_t   end_index;

  modport source (output valid, output value, output end_valid, output end_index,
                  input ready);
  modport sink   (input valid, input value, input end_valid, input end_index,
                  output ready);
endinterface

[rtl/ascii_number_parser.sv]
// ----------------------------------------------------------------------------
// ascii_number_parser
// Streaming ASCII string to 64-bit integer converter.
// ----------------------------------------------------------------------------
// The block takes one character item per clock cycle, sustained, with no gaps
// between strings. Each character is first registered, then handled by the
// parse state update, whose accumulator loop (a 64 by 5 bit multiply-add by
// the radix and the wrap compare) sets that one-cycle rate. When the item
// marked last is handled, the string state is snapshotted and cleared, and
// the closing step (implied terminator, sign and masking) runs from the
// snapshot into the result register. A stall on the result side holds the
// pipeline; the three registers keep it moving whenever the result is taken.
// Configuration writes must be made while the block is idle.
// ----------------------------------------------------------------------------
module ascii_number_parser #(
  parameter int MAX_CHARS = anp_pkg::MaxCharsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  anp_pkg::reg_index_t           cfg_index,
  input  logic [anp_pkg::BaseW-1:0]     cfg_data,
  anp_in_if.sink                        in_ch,
  anp_out_if.source                     out_ch
);
  import anp_pkg::*;

  localparam int PosW = $clog2(MAX_CHARS + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_CHARS);

  // Configuration registers.
  base_t number_base;
  logic  signed_parse;

  // Input register.
  logic  in_valid_r;
  char_t in_char;
  logic  in_last;

  // Per-string parse state.
  phase_t          phase, phase_next;
  value_t          acc, acc_next;
  base_t           active_base, active_base_next;
  logic            negate, negate_next;
  logic [PosW-1:0] char_pos, char_pos_next;
  logic [PosW-1:0] end_pos, end_pos_next;
  logic            end_rec, end_rec_next;

  // Snapshot of a closed string.
  logic            f_valid;
  phase_t          f_phase;
  value_t          f_acc;
  logic            f_negate;
  logic [PosW-1:0] f_end_pos;
  logic            f_end_rec;
  logic [PosW-1:0] f_nul_pos;

  // Result register.
  logic   o_valid;
  value_t o_value;
  logic   o_end_valid;
  end_t   o_end_index;

  // Handshake and pipeline advance.
  logic o_load, f_free, step, in_ready;

  assign o_load   = f_valid && (!o_valid || out_ch.ready);
  assign f_free   = !f_valid || o_load;
  assign step     = in_valid_r && (!in_last || f_free);
  assign in_ready = !in_valid_r || step;

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = o_valid;
  assign out_ch.value     = o_value;
  assign out_ch.end_valid = o_end_valid;
  assign out_ch.end_index = o_end_index;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base  <= BaseDec;
      signed_parse <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NUMBER_BASE:  number_base  <= cfg_data;
        REG_SIGNED_PARSE: signed_parse <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_char <= in_ch.char_code;
      in_last <= in_ch.is_last;
    end
  end

  // Character classification.
  logic  is_space, is_zero, is_x, is_sign, is_minus;
  base_t digit;

  assign is_space = is_ws(in_char);
  assign is_zero  = (in_char == CharZero);
  assign is_x     = (in_char == CharLowerX) || (in_char == CharUpperX);
  assign is_minus = (in_char == CharMinus);
  assign is_sign  = is_minus || (in_char == CharPlus);
  assign digit    = digit_of(in_char);

  // Radix used by a digit taken in the current phase.
  base_t mul_base;

  always_comb begin
    unique case (phase)
      PH_WS1, PH_WS2: mul_base = (number_base == BaseAuto) ? BaseDec : number_base;
      PH_X:           mul_base = BaseHex;
      default:        mul_base = active_base;
    endcase
  end

  // Multiply-add and wrap detection.
  logic [ValueW+BaseW-1:0] prod_full;
  value_t                  acc_sum;
  logic                    acc_stop;

  assign prod_full = acc * mul_base;
  assign acc_sum   = prod_full[ValueW-1:0] + {{(ValueW-BaseW){1'b0}}, digit};
  assign acc_stop  = (digit >= mul_base) || (acc > acc_sum);

  // Phase update for one character.
  logic take_digit;

  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    active_base_next = active_base;
    negate_next      = negate;
    end_pos_next     = end_pos;
    end_rec_next     = end_rec;
    take_digit       = 1'b0;

    unique case (phase)
      PH_WS1, PH_WS2: begin
        if (!is_space) begin
          if ((phase == PH_WS1) && signed_parse && is_sign) begin
            negate_next = is_minus;
            phase_next  = PH_WS2;
          end else if (number_base > BaseHex) begin
            end_rec_next = 1'b0;
            phase_next   = PH_DONE;
          end else if ((number_base == BaseAuto) && is_zero) begin
            active_base_next = BaseOct;
            phase_next       = PH_ZERO;
          end else if ((number_base == BaseHex) && is_zero) begin
            phase_next = PH_HEXZERO;
          end else begin
            active_base_next = mul_base;
            take_digit       = 1'b1;
          end
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          phase_next = PH_X;
        end else begin
          take_digit = 1'b1;
        end
      end
      PH_X: begin
        if (digit != DigitNone) begin
          active_base_next = BaseHex;
          take_digit       = 1'b1;
        end else begin
          end_rec_next = 1'b0;
          phase_next   = PH_DONE;
        end
      end
      PH_HEXZERO: begin
        if (is_x) begin
          active_base_next = BaseHex;
          phase_next       = PH_DIGITS;
        end else begin
          end_rec_next = 1'b0;
          phase_next   = PH_DONE;
        end
      end
      PH_DIGITS: take_digit = 1'b1;
      default: ;
    endcase

    // A digit either extends the number or closes it at this offset.
    if (take_digit) begin
      if (acc_stop) begin
        end_pos_next = char_pos;
        end_rec_next = 1'b1;
        phase_next   = PH_DONE;
      end else begin
        acc_next   = acc_sum;
        phase_next = PH_DIGITS;
      end
    end
  end

  // Saturating character position.
  assign char_pos_next = (char_pos < PosMax) ? (char_pos + 1'b1) : char_pos;

  // Parse state registers; the last item clears them for the next string.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WS1;
      acc         <= '0;
      active_base <= BaseAuto;
      negate      <= 1'b0;
      char_pos    <= '0;
      end_pos     <= '0;
      end_rec     <= 1'b0;
    end else if (step) begin
      if (in_last) begin
        phase       <= PH_WS1;
        acc         <= '0;
        active_base <= BaseAuto;
        negate      <= 1'b0;
        char_pos    <= '0;
        end_pos     <= '0;
        end_rec     <= 1'b0;
      end else begin
        phase       <= phase_next;
        acc         <= acc_next;
        active_base <= active_base_next;
        negate      <= negate_next;
        char_pos    <= char_pos_next;
        end_pos     <= end_pos_next;
        end_rec     <= end_rec_next;
      end
    end
  end

  // Snapshot of the closed string.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (step && in_last) begin
      f_valid <= 1'b1;
    end else if (o_load) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      f_phase   <= phase_next;
      f_acc     <= acc_next;
      f_negate  <= negate_next;
      f_end_pos <= end_pos_next;
      f_end_rec <= end_rec_next;
      f_nul_pos <= char_pos_next;
    end
  end

  // Closing step: an unfinished parse sees a terminator at the next offset.
  logic            fin_rec;
  logic [PosW-1:0] fin_end_pos;
  value_t          fin_value;
  logic [PosW+EndW-1:0] fin_end_ext;

  always_comb begin
    fin_rec     = f_end_rec;
    fin_end_pos = f_end_pos;
    unique case (f_phase)
      PH_WS1, PH_WS2: begin
        fin_rec     = (number_base <= BaseHex);
        fin_end_pos = f_nul_pos;
      end
      PH_ZERO, PH_DIGITS: begin
        fin_rec     = 1'b1;
        fin_end_pos = f_nul_pos;
      end
      PH_X, PH_HEXZERO: fin_rec = 1'b0;
      default: ;
    endcase
  end

  assign fin_value   = f_negate ? (value_t'(0) - f_acc) : f_acc;
  assign fin_end_ext = {{EndW{1'b0}}, fin_end_pos};

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_load) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_value     <= fin_rec ? fin_value : '0;
      o_end_valid <= fin_rec;
      o_end_index <= fin_rec ? fin_end_ext[EndW-1:0] : '0;
    end
  end

  // A result without an end offset carries zeros only.
  assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_end_valid) |-> ((o_value == '0) && (o_end_index == '0)))
    else $error("result without end offset carries nonzero fields");

  // The last item of a string leaves the parse state cleared.
  assert property (@(posedge clk) disable iff (rst)
    (step && in_last) |=> ((phase == PH_WS1) && (char_pos == '0) && !end_rec))
    else $error("parse state not cleared after last item");

  // The position counter saturates at the string length limit.
  assert property (@(posedge clk) disable iff (rst) char_pos <= PosMax)
    else $error("character position beyond limit");

  // An end offset is only recorded once the number is closed.
  assert property (@(posedge clk) disable iff (rst) end_rec |-> (phase == PH_DONE))
    else $error("end offset recorded in an open parse");

  // No sign is seen before the first non-whitespace character.
  assert property (@(posedge clk) disable iff (rst) (phase == PH_WS1) |-> !negate)
    else $error("negate set during leading whitespace");

  // A snapshot waiting on a stalled result blocks the next last item.
  assert property (@(posedge clk) disable iff (rst)
    (f_valid && o_valid && !out_ch.ready) |-> !(step && in_last))
    else $error("closed string overwrote a pending snapshot");

endmodule

[tb/anp_parse_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anp_parse_checker
// Watches the character, result and register ports of the ASCII number
// parser, predicts the result of every string and compares each result item
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module anp_parse_checker #(
  parameter int MAX_CHARS = anp_pkg::MaxCharsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  anp_pkg::reg_index_t cfg_index,
  input  anp_pkg::base_t      cfg_data,
  anp_in_if                   in_ch,
  anp_out_if                  out_ch,
  output int                  mismatches,
  output int                  pending,
  output int                  strings_done,
  output int                  empty_results,
  output int                  overflow_stops
);
  import anp_pkg::*;

  typedef struct {
    value_t value;
    logic   end_valid;
    end_t   end_index;
  } parse_result_t;

  // Register copies.
  base_t radix_cfg  = BaseDec;
  logic  signed_cfg = 1'b0;

  // State of the string being parsed.
  phase_t      phase    = PH_WS1;
  value_t      acc      = '0;
  base_t       radix    = '0;
  logic        negative = 1'b0;
  int unsigned pos      = 0;
  int unsigned end_pos  = 0;
  logic        end_seen = 1'b0;

  parse_result_t expected_results[$];

  int err_count   = 0;
  int done_count  = 0;
  int empty_count = 0;
  int wrap_count  = 0;

  function automatic logic blank_char(input char_t c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic x_char(input char_t c);
    return (c == CharLowerX) || (c == CharUpperX);
  endfunction

  // Hex value of a character, or DigitNone when it is no hex digit.
  function automatic int hex_digit(input char_t c);
    if ((c >= CharZero) && (c <= CharNine)) return int'(c - CharZero);
    if ((c >= CharLowerA) && (c <= CharLowerF)) return int'(c - CharLowerA) + int'(LetterBias);
    if ((c >= CharUpperA) && (c <= CharUpperF)) return int'(c - CharUpperA) + int'(LetterBias);
    return int'(DigitNone);
  endfunction

  function automatic void close_at(input int unsigned p);
    end_pos  = p;
    end_seen = 1'b1;
    phase    = PH_DONE;
  endfunction

  function automatic void close_empty();
    acc      = '0;
    end_seen = 1'b0;
    phase    = PH_DONE;
  endfunction

  // Multiply-add one digit; a non-digit or a wrap of the sum ends the number.
  function automatic void add_digit(input char_t c, input int unsigned p);
    int     d;
    value_t nxt;
    d = hex_digit(c);
    if (d >= int'(radix)) begin
      close_at(p);
      return;
    end
    nxt = value_t'(radix) * acc + value_t'(d);
    if (acc > nxt) begin
      wrap_count++;
      close_at(p);
      return;
    end
    acc   = nxt;
    phase = PH_DIGITS;
  endfunction

  // First character of the number proper: pick the radix.
  function automatic void start_number(input char_t c, input int unsigned p);
    if (radix_cfg > BaseHex) begin
      close_empty();
    end else if (radix_cfg == BaseAuto) begin
      if (c == CharZero) begin
        radix = BaseOct;
        phase = PH_ZERO;
      end else begin
        radix = BaseDec;
        add_digit(c, p);
      end
    end else if ((radix_cfg == BaseHex) && (c == CharZero)) begin
      phase = PH_HEXZERO;
    end else begin
      radix = radix_cfg;
      add_digit(c, p);
    end
  endfunction

  function automatic void consume(input char_t c, input int unsigned p);
    case (phase)
      PH_WS1: begin
        if (!blank_char(c)) begin
          if (signed_cfg && ((c == CharMinus) || (c == CharPlus))) begin
            negative = (c == CharMinus);
            phase    = PH_WS2;
          end else begin
            start_number(c, p);
          end
        end
      end
      PH_WS2: begin
        if (!blank_char(c)) start_number(c, p);
      end
      PH_ZERO: begin
        if (x_char(c)) phase = PH_X;
        else add_digit(c, p);
      end
      PH_X: begin
        if (hex_digit(c) < int'(DigitNone)) begin
          radix = BaseHex;
          add_digit(c, p);
        end else begin
          close_empty();
        end
      end
      PH_HEXZERO: begin
        if (x_char(c)) begin
          radix = BaseHex;
          phase = PH_DIGITS;
        end else begin
          close_empty();
        end
      end
      PH_DIGITS: add_digit(c, p);
      default: ;
    endcase
  endfunction

  function automatic void clear_string();
    phase    = PH_WS1;
    acc      = '0;
    radix    = '0;
    negative = 1'b0;
    pos      = 0;
    end_pos  = 0;
    end_seen = 1'b0;
  endfunction

  // One accepted character; the last one of a string closes it and queues
  // the predicted result, with a terminator assumed if still parsing.
  function automatic void take_char(input char_t c, input logic last);
    parse_result_t r;
    consume(c, pos);
    if (pos < MAX_CHARS) pos++;
    if (last) begin
      if (phase != PH_DONE) consume(CharNul, pos);
      r.value     = negative ? value_t'(0) - acc : acc;
      if (!end_seen) r.value = '0;
      r.end_valid = end_seen;
      r.end_index = end_seen ? end_t'(end_pos) : '0;
      expected_results.push_back(r);
      clear_string();
    end
  endfunction

  function automatic void compare_result();
    parse_result_t want;
    if (expected_results.size() == 0) begin
      err_count++;
      if (err_count <= 10) begin
        $display("[%0t] Unexpected result item: value=%h end_valid=%b end_index=%0d",
                 $time, out_ch.value, out_ch.end_valid, out_ch.end_index);
      end
      return;
    end
    want = expected_results.pop_front();
    done_count++;
    if (!want.end_valid) empty_count++;
    if ((out_ch.value !== want.value) || (out_ch.end_valid !== want.end_valid) ||
        (out_ch.end_index !== want.end_index)) begin
      err_count++;
      if (err_count <= 10) begin
        $display("[%0t] Result mismatch: expected value=%h end_valid=%b end_index=%0d",
                 $time, want.value, want.end_valid, want.end_index);
        $display("[%0t]                  actual   value=%h end_valid=%b end_index=%0d",
                 $time, out_ch.value, out_ch.end_valid, out_ch.end_index);
      end
    end
  endfunction

  // Results are compared before the character of the same edge is taken.
  always @(posedge clk) begin
    if (rst) begin
      radix_cfg  = BaseDec;
      signed_cfg = 1'b0;
      clear_string();
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NUMBER_BASE:  radix_cfg  = cfg_data;
          REG_SIGNED_PARSE: signed_cfg = cfg_data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) compare_result();
      if (in_ch.valid && in_ch.ready) take_char(in_ch.char_code, in_ch.is_last);
    end
    mismatches     <= err_count;
    pending        <= expected_results.size();
    strings_done   <= done_count;
    empty_results  <= empty_count;
    overflow_stops <= wrap_count;
  end

endmodule

[tb/tb_ascii_number_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_number_parser
// Drives strings into the ASCII number parser and judges the run. A short
// directed set hits whitespace, signs, terminators, forced hex, auto radix
// and overflow, and short strings meet one long result-side hold; then
// random strings run under a sweep of radix and sign settings, with random
// gaps on both channels. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ascii_number_parser;
  import anp_pkg::*;

  localparam int ClockPeriod    = 10;
  localparam int MaxChars       = MaxCharsDefault;
  localparam int CycleLimit     = 200000;
  localparam int PressureCycles = 300;
  localparam int PhaseItems     = 50;
  localparam int NumPhases      = 10;

  localparam char_t CharDot    = 8'h2E;
  localparam char_t CharLowerG = 8'h67;
  localparam char_t CharHigh   = 8'hFF;

  // Radix and sign settings of the random phases; entry 7 is drawn at random.
  localparam base_t PhaseBase [NumPhases] = '{BaseAuto, BaseDec, BaseHex, 5'd1, 5'd31,
                                              5'd17, BaseOct, 5'd7, BaseAuto, BaseHex};
  localparam bit PhaseSigned [NumPhases] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                             1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

  logic       clk;
  logic       rst;
  logic       cfg_write;
  reg_index_t cfg_index;
  base_t      cfg_data;

  anp_in_if  in_ch ();
  anp_out_if out_ch ();

  int mismatches;
  int pending;
  int strings_done;
  int empty_results;
  int overflow_stops;

  int    cycle_count   = 0;
  int    items_sent    = 0;
  int    settings_run  = 0;
  bit    sender_steady = 1'b0;
  bit    pressure_req  = 1'b0;
  bit    pressure_on   = 1'b0;
  base_t cur_base      = BaseDec;
  char_t text_buf[$];

  ascii_number_parser #(
    .MAX_CHARS (MaxChars)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  anp_parse_checker #(
    .MAX_CHARS (MaxChars)
  ) parse_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatches     (mismatches),
    .pending        (pending),
    .strings_done   (strings_done),
    .empty_results  (empty_results),
    .overflow_stops (overflow_stops)
  );

  initial begin
    clk = 1'b0;
    forever #(ClockPeriod / 2) clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CycleLimit);
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("Simulation FAILED");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int gap_length(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Result side: random stalls, open stretches, and the long hold on request.
  initial begin
    int hold;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (pressure_req) begin
        out_ch.ready <= 1'b0;
        pressure_on = 1'b1;
        repeat (PressureCycles) @(posedge clk);
        pressure_on  = 1'b0;
        pressure_req = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else begin
        hold = gap_length(1'b0);
        if (hold > 0) begin
          out_ch.ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Offer one character and hold it until the parser takes it.
  task automatic send_char(input char_t c, input logic last);
    int gap;
    gap = gap_length(sender_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.is_last   <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(char_t'(s[i]));
  endfunction

  // Let every outstanding result drain before touching the registers.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input base_t b, input bit sgn);
    cfg_write <= 1'b1;
    cfg_index <= REG_NUMBER_BASE;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= REG_SIGNED_PARSE;
    cfg_data  <= base_t'(sgn);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    cur_base = b;
    settings_run++;
  endtask

  function automatic char_t digit_char(input int v);
    if (v < 10) return CharZero + char_t'(v);
    return ($urandom_range(0, 1) ? CharLowerA : CharUpperA) + char_t'(v - 10);
  endfunction

  function automatic char_t blank_char();
    int w;
    w = $urandom_range(0, 5);
    if (w == 5) return CharSpace;
    return CharTab + char_t'(w);
  endfunction

  function automatic char_t odd_char();
    case ($urandom_range(0, 12))
      0:       return CharNul;
      1:       return CharSpace;
      2:       return CharTab;
      3:       return CharPlus;
      4:       return CharMinus;
      5:       return CharZero;
      6:       return CharLowerX;
      7:       return CharUpperX;
      8:       return CharNine;
      9:       return CharLowerF;
      10:      return CharUpperA;
      11:      return CharLowerG;
      default: return CharDot;
    endcase
  endfunction

  function automatic char_t random_byte();
    return char_t'($urandom_range(0, 255));
  endfunction

  // A well-formed number with random content: blanks, sign, radix prefix,
  // digits (now and then one out of range), then an optional terminator.
  function automatic void build_number();
    int r;
    int digits;
    int digit_radix;
    if ($urandom_range(0, 9) >= 6) begin
      repeat ($urandom_range(1, 3)) text_buf.push_back(blank_char());
    end
    if ($urandom_range(0, 1)) begin
      text_buf.push_back($urandom_range(0, 1) ? CharMinus : CharPlus);
      if ($urandom_range(0, 4) == 0) text_buf.push_back(blank_char());
    end
    if (cur_base == BaseAuto) digit_radix = 10;
    else if (cur_base > BaseHex) digit_radix = 16;
    else digit_radix = int'(cur_base);
    r = $urandom_range(0, 9);
    if (((cur_base == BaseAuto) || (cur_base == BaseHex)) && (r < 4)) begin
      text_buf.push_back(CharZero);
      text_buf.push_back($urandom_range(0, 1) ? CharLowerX : CharUpperX);
      digit_radix = 16;
    end else if (r < 6) begin
      text_buf.push_back(CharZero);
      if (cur_base == BaseAuto) digit_radix = 8;
    end
    digits = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 22) : $urandom_range(1, 6);
    repeat (digits) begin
      if ($urandom_range(0, 11) == 0) text_buf.push_back(digit_char($urandom_range(0, 15)));
      else text_buf.push_back(digit_char($urandom_range(0, digit_radix - 1)));
    end
    r = $urandom_range(0, 19);
    if (r >= 8) begin
      if (r < 13) text_buf.push_back(CharNul);
      else text_buf.push_back($urandom_range(0, 1) ? odd_char() : random_byte());
      repeat ($urandom_range(0, 3)) text_buf.push_back(random_byte());
    end
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 6)) begin
      text_buf.push_back($urandom_range(0, 1) ? random_byte() : odd_char());
    end
  endfunction

  // Stimulus.
  initial begin
    int start_count;
    base_t b;
    bit sgn;
    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_index       <= REG_NUMBER_BASE;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.is_last   <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: decimal, unsigned. Characters after a terminator are
    // ignored, and a minus is no sign here.
    add_text(" 7");
    text_buf.push_back(CharNul);
    text_buf.push_back(CharHigh);
    send_text();
    add_text("-");
    send_text();

    // Forced hex: a leading zero without x gives no end offset, and a one
    // followed by sixteen zeros overflows on the last digit.
    settle();
    set_config(BaseHex, 1'b1);
    add_text("-0g");
    send_text();
    add_text("1");
    repeat (16) text_buf.push_back(CharZero);
    send_text();

    // Auto radix: 0x with no hex digit, then an octal number.
    settle();
    set_config(BaseAuto, 1'b1);
    add_text("0x");
    send_text();
    add_text("07");
    send_text();

    // Result side held off while short strings keep coming, so the parser
    // fills up and stalls its input.
    in_ch.valid   <= 1'b0;
    sender_steady = 1'b1;
    pressure_req  = 1'b1;
    wait (pressure_on);
    repeat (15) begin
      repeat ($urandom_range(1, 2)) text_buf.push_back(digit_char($urandom_range(0, 9)));
      send_text();
    end
    sender_steady = 1'b0;

    // Random strings under a sweep of register settings.
    for (int p = 0; p < NumPhases; p++) begin
      b   = PhaseBase[p];
      sgn = PhaseSigned[p];
      if (p == 7) begin
        b   = base_t'($urandom_range(2, 15));
        sgn = $urandom_range(0, 1);
      end
      settle();
      set_config(b, sgn);
      start_count = items_sent;
      while (items_sent - start_count < PhaseItems) begin
        sender_steady = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) < 7) build_number();
        else build_noise();
        send_text();
      end
      sender_steady = 1'b0;
    end

    // Drain and give the verdict.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Checked %0d strings from %0d characters under %0d register settings;",
             strings_done, items_sent, settings_run);
    $display("%0d ended with no offset, %0d stopped on overflow, %0d mismatches.",
             empty_results, overflow_stops, mismatches);
    if ((mismatches == 0) && (pending == 0)) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[ascii_number_parser.f]
rtl/anp_pkg.sv
rtl/anp_in_if.sv
rtl/anp_out_if.sv
rtl/ascii_number_parser.sv
tb/anp_parse_checker.sv
tb/tb_ascii_number_parser.sv
